// File: rtl/quarter_wave_sine_interpolator_assert.svh
// Assertion macros shared by the sine interpolator RTL.
`ifndef QUARTER_WAVE_SINE_INTERPOLATOR_ASSERT_SVH
`define QUARTER_WAVE_SINE_INTERPOLATOR_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define QWSI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qwsi same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define QWSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qwsi next-cycle check failed");

`endif

// File: rtl/qwsi_pkg.sv
// Constants and types shared by the sine interpolator modules.
package qwsi_pkg;

   // Phase word and table geometry.
   localparam int PHASE_IN_BITS = 24;
   localparam int PHASE_BITS    = 24;
   localparam int SEGMENTS      = 512;
   localparam int QUARTER_SHIFT = PHASE_BITS - 2;
   localparam int SEG2          = 2 * SEGMENTS;
   localparam int NUM_SAMPLES   = SEG2 + 1;
   localparam int ADDR_BITS     = $clog2(NUM_SAMPLES);
   localparam int SAMPLE_BITS   = 17;
   localparam int OUT_BITS      = 18;
   localparam int SAMPLE_MAX    = 65536;

   // Widths of the scaled position and its integer part.
   localparam int POS_BITS  = QUARTER_SHIFT + 1 + $clog2(SEG2 + 1);
   localparam int IDX_BITS  = POS_BITS - QUARTER_SHIFT;
   localparam int PROD_BITS = SAMPLE_BITS + QUARTER_SHIFT;

   // Rounding constant for the interpolation step.
   localparam logic [63:0] HALF_QUARTER = 64'd1 << (QUARTER_SHIFT - 1);

   // Folded angle word handed from the fold stage to the table and interpolator.
   typedef struct packed {
      logic                   valid;
      logic                   neg;
      logic [ADDR_BITS-1:0]   addr_a;
      logic [ADDR_BITS-1:0]   addr_b;
      logic [QUARTER_SHIFT-1:0] frac;
   } fold_type;

endpackage

// File: rtl/qwsi_fold.sv
// Input register and quarter-wave fold that yields table addresses and fraction.
module qwsi_fold
   import qwsi_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [PHASE_IN_BITS-1:0] phase,
   output fold_type                 fold
);

   localparam logic [QUARTER_SHIFT:0] QUARTER = {1'b1, {QUARTER_SHIFT{1'b0}}};

   logic                  valid1_ff;
   logic [PHASE_BITS-1:0] phase1_ff;
   fold_type              fold_ff;
   fold_type              fold_in;

   logic [QUARTER_SHIFT:0]   x_low;
   logic [QUARTER_SHIFT:0]   x_fold;
   logic [POS_BITS-1:0]      pos;
   logic [IDX_BITS-1:0]      idx;
   logic                     at_end;

   // The input register keeps only the bits that make up one circle.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         phase1_ff <= PHASE_BITS'(phase);
      end
   end

   // Fold by half wave and quarter wave, then scale into table steps.
   always_comb begin
      x_low  = {1'b0, phase1_ff[QUARTER_SHIFT-1:0]};
      x_fold = phase1_ff[QUARTER_SHIFT] ? (QUARTER - x_low) : x_low;
      pos    = POS_BITS'(x_fold) * POS_BITS'(SEG2);
      idx    = pos[POS_BITS-1:QUARTER_SHIFT];
      at_end = (idx >= IDX_BITS'(SEG2));

      fold_in.valid  = valid1_ff;
      fold_in.neg    = phase1_ff[QUARTER_SHIFT+1];
      fold_in.frac   = pos[QUARTER_SHIFT-1:0];
      fold_in.addr_a = at_end ? ADDR_BITS'(SEG2) : ADDR_BITS'(idx);
      fold_in.addr_b = at_end ? ADDR_BITS'(SEG2) : ADDR_BITS'(idx + IDX_BITS'(1));
   end

   // Only the valid bit is cleared; the payload simply follows it.
   always_ff @(posedge clock) begin
      if (reset) begin
         fold_ff.valid <= 1'b0;
      end else begin
         fold_ff.valid <= fold_in.valid;
      end
      fold_ff.neg    <= fold_in.neg;
      fold_ff.frac   <= fold_in.frac;
      fold_ff.addr_a <= fold_in.addr_a;
      fold_ff.addr_b <= fold_in.addr_b;
   end

   assign fold = fold_ff;

endmodule

// File: rtl/qwsi_rom.sv
// Dual-read quarter-wave sine sample ROM with registered read data.
module qwsi_rom
   import qwsi_pkg::*;
(
   input  logic                   clock,
   input  logic [ADDR_BITS-1:0]   addr_a,
   input  logic [ADDR_BITS-1:0]   addr_b,
   output logic [SAMPLE_BITS-1:0] data_a,
   output logic [SAMPLE_BITS-1:0] data_b
);

   typedef logic [SAMPLE_BITS-1:0] sample_table_type [NUM_SAMPLES];

   localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
   localparam logic [63:0] ANGLE_DEN = 64'(4 * SEGMENTS);
   localparam logic [63:0] PI_STEP  = PI_Q60 / ANGLE_DEN;
   localparam logic [63:0] PI_REM   = PI_Q60 % ANGLE_DEN;

   // Product of two Q60 fractions, back in Q60.
   function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[123:60];
   endfunction

   // Divides a series term by (2n)(2n+1) for the n-th Taylor term.
   function automatic logic [63:0] series_div(input logic [63:0] v, input int n);
      logic [63:0] res;
      case (n)
         1:       res = v / 64'd6;
         2:       res = v / 64'd20;
         3:       res = v / 64'd42;
         4:       res = v / 64'd72;
         5:       res = v / 64'd110;
         6:       res = v / 64'd156;
         7:       res = v / 64'd210;
         8:       res = v / 64'd272;
         9:       res = v / 64'd342;
         10:      res = v / 64'd420;
         11:      res = v / 64'd506;
         12:      res = v / 64'd600;
         13:      res = v / 64'd702;
         14:      res = v / 64'd812;
         default: res = v;
      endcase
      return res;
   endfunction

   // Sine of a Q60 angle in the first quadrant by its Taylor series.
   function automatic logic [63:0] sine_q60(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x2   = mul_q60(x, x);
      term = x;
      sum  = x;
      for (int n = 1; n <= 14; n++) begin
         term = series_div(mul_q60(term, x2), n);
         if ((n % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   // Builds the rounded Q1.16 samples over the quarter wave.
   function automatic sample_table_type build_sine_table();
      sample_table_type tbl;
      logic [63:0]      theta;
      logic [63:0]      s;
      for (int k = 0; k < NUM_SAMPLES; k++) begin
         theta = PI_STEP * 64'(k) + (PI_REM * 64'(k)) / ANGLE_DEN;
         s     = (sine_q60(theta) + (64'd1 << 43)) >> 44;
         if (s > 64'(SAMPLE_MAX)) begin
            s = 64'(SAMPLE_MAX);
         end
         tbl[k] = SAMPLE_BITS'(s);
      end
      return tbl;
   endfunction

   localparam sample_table_type SINE_TABLE = build_sine_table();

   logic [SAMPLE_BITS-1:0] data_a_ff;
   logic [SAMPLE_BITS-1:0] data_b_ff;

   // Both neighbors are read in the same cycle.
   always_ff @(posedge clock) begin
      data_a_ff <= SINE_TABLE[addr_a];
      data_b_ff <= SINE_TABLE[addr_b];
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

// File: rtl/qwsi_interp.sv
// Linear interpolation between neighboring samples, rounding and sign restore.
module qwsi_interp
   import qwsi_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  fold_type                   fold,
   input  logic [SAMPLE_BITS-1:0]     sample_a,
   input  logic [SAMPLE_BITS-1:0]     sample_b,
   output logic                       out_valid,
   output logic signed [OUT_BITS-1:0] out_value
);

   logic                     valid3_ff;
   logic                     neg3_ff;
   logic [QUARTER_SHIFT-1:0] frac3_ff;

   logic                     valid4_ff;
   logic                     neg4_ff;
   logic [SAMPLE_BITS-1:0]   base4_ff;
   logic [PROD_BITS-1:0]     prod4_ff;
   logic [SAMPLE_BITS-1:0]   diff;
   logic [PROD_BITS-1:0]     prod4_in;

   logic                     valid5_ff;
   logic [OUT_BITS-1:0]      value5_ff;
   logic [PROD_BITS:0]       rounded;
   logic [OUT_BITS-1:0]      mag;
   logic [OUT_BITS-1:0]      value5_in;

   // Valid bits travel alongside the table read and the arithmetic.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else begin
         valid3_ff <= fold.valid;
         valid4_ff <= valid3_ff;
         valid5_ff <= valid4_ff;
      end
   end

   // Fraction and sign wait while the samples are read.
   always_ff @(posedge clock) begin
      neg3_ff  <= fold.neg;
      frac3_ff <= fold.frac;
   end

   // Slope times fraction; the samples never fall, but a guard keeps it at zero.
   always_comb begin
      diff     = (sample_b >= sample_a) ? (sample_b - sample_a) : '0;
      prod4_in = PROD_BITS'(diff) * PROD_BITS'(frac3_ff);
   end

   always_ff @(posedge clock) begin
      neg4_ff  <= neg3_ff;
      base4_ff <= sample_a;
      prod4_ff <= prod4_in;
   end

   // Round half up, add to the base sample, then negate in the lower half circle.
   always_comb begin
      rounded   = {1'b0, prod4_ff} + (PROD_BITS + 1)'(HALF_QUARTER);
      mag       = OUT_BITS'(base4_ff) + OUT_BITS'(rounded[PROD_BITS:QUARTER_SHIFT]);
      value5_in = neg4_ff ? (~mag + OUT_BITS'(1)) : mag;
   end

   always_ff @(posedge clock) begin
      value5_ff <= value5_in;
   end

   assign out_valid = valid5_ff;
   assign out_value = $signed(value5_ff);

endmodule

// File: rtl/quarter_wave_sine_interpolator.sv
// One word per cycle; busy is never raised, as no stage ever stalls.
// The stages are input register, fold, table read, multiply, and round with output.
// Reset is synchronous and clears all valid bits; the table needs no clearing.
// The result strobe is high for exactly one cycle per word.
`include "quarter_wave_sine_interpolator_assert.svh"

module quarter_wave_sine_interpolator
   import qwsi_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [PHASE_IN_BITS-1:0]   req_phase,
   output logic                       rsp_valid,
   output logic signed [OUT_BITS-1:0] rsp_sine_value
);

   fold_type               fold;
   logic [SAMPLE_BITS-1:0] sample_a;
   logic [SAMPLE_BITS-1:0] sample_b;
   logic                   accept;
   logic                   out_in_range;
   logic                   rom_pair_ok;
   logic                   rom_in_bound;

   // The pipeline never stalls, so every start is taken.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   qwsi_fold u_fold (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .phase  (req_phase),
      .fold   (fold)
   );

   qwsi_rom u_rom (
      .clock  (clock),
      .addr_a (fold.addr_a),
      .addr_b (fold.addr_b),
      .data_a (sample_a),
      .data_b (sample_b)
   );

   qwsi_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .fold      (fold),
      .sample_a  (sample_a),
      .sample_b  (sample_b),
      .out_valid (rsp_valid),
      .out_value (rsp_sine_value)
   );

   // Conditions checked by the assertions below.
   assign out_in_range = (rsp_sine_value <= 18'sd65536) && (rsp_sine_value >= -18'sd65536);
   assign rom_pair_ok  = (fold.addr_b == fold.addr_a + ADDR_BITS'(1)) ||
                         ((fold.addr_a == ADDR_BITS'(SEG2)) &&
                          (fold.addr_b == ADDR_BITS'(SEG2)));
   assign rom_in_bound = (fold.addr_a <= ADDR_BITS'(SEG2)) &&
                         (fold.addr_b <= ADDR_BITS'(SEG2));

   // Results stay within the unit range of Q1.16.
   `QWSI_ASSERT_SAME(a_out_range, clock, reset, rsp_valid, out_in_range)
   // The table is always read at neighboring entries, or twice at the last one.
   `QWSI_ASSERT_SAME(a_rom_pair, clock, reset, fold.valid, rom_pair_ok)
   // A word never reads beyond the last sample.
   `QWSI_ASSERT_SAME(a_rom_bound, clock, reset, fold.valid, rom_in_bound)
   // An accepted word reaches the fold output and then gives its result.
   `QWSI_ASSERT_NEXT(a_accept_flow, clock, reset, accept, 1'b1 ##1 fold.valid ##3 rsp_valid)

endmodule

// File: sim/tb.sv
// Self-checking testbench for the quarter-wave sine interpolator.
`timescale 1ns / 1ps

module tb;
   import qwsi_pkg::*;

   // Quarter circle in phase units, and pi in unsigned Q60 for the table build.
   localparam bit [63:0] QUARTER    = 64'd1 << QUARTER_SHIFT;
   localparam bit [63:0] PI_Q60     = 64'h3243F6A8885A308D;
   localparam int        SERIES_LEN = 14;
   localparam int        DRAIN_CYCLES = 12;

   typedef struct {
      logic [PHASE_IN_BITS-1:0] phase;
      logic [OUT_BITS-1:0]      sine;
   } sine_word_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [PHASE_IN_BITS-1:0]   req_phase;
   logic                       rsp_valid;
   logic signed [OUT_BITS-1:0] rsp_sine_value;

   bit [SAMPLE_BITS-1:0] quarter_sine_table [0:NUM_SAMPLES-1];
   sine_word_type        pending_sines [$];
   int                   mismatches;
   int                   words_sent;
   int                   words_checked;
   bit                   no_gaps;

   quarter_wave_sine_interpolator dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_phase      (req_phase),
      .rsp_valid      (rsp_valid),
      .rsp_sine_value (rsp_sine_value)
   );

   // Free-running 100 MHz clock.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // (a * b) >> 60 for unsigned Q60 operands.
   function automatic bit [63:0] q60_product(bit [63:0] a, bit [63:0] b);
      bit [127:0] wide;
      wide = {64'd0, a} * {64'd0, b};
      return wide[123:60];
   endfunction

   // Taylor series for sin(x), x in [0, pi/2], all in unsigned Q60.
   function automatic bit [63:0] q60_sine(bit [63:0] x);
      bit [63:0] x_sq;
      bit [63:0] term;
      bit [63:0] sum;
      x_sq = q60_product(x, x);
      term = x;
      sum  = x;
      for (int n = 1; n <= SERIES_LEN; n++) begin
         term = q60_product(term, x_sq) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   // Fills the expected sample table, rounded half up to Q1.16 and clamped at one.
   task automatic build_sine_table();
      bit [63:0] steps;
      bit [63:0] step_q;
      bit [63:0] step_r;
      bit [63:0] theta;
      bit [63:0] sample;
      steps  = 64'(4 * SEGMENTS);
      step_q = PI_Q60 / steps;
      step_r = PI_Q60 % steps;
      for (int k = 0; k < NUM_SAMPLES; k++) begin
         theta  = step_q * 64'(k) + (step_r * 64'(k)) / steps;
         sample = (q60_sine(theta) + (64'd1 << 43)) >> 44;
         if (sample > 64'(SAMPLE_MAX)) sample = 64'(SAMPLE_MAX);
         quarter_sine_table[k] = sample[SAMPLE_BITS-1:0];
      end
   endtask

   // Folds the phase into the first quarter, interpolates, and applies the sign.
   function automatic logic [OUT_BITS-1:0] predict_sine(logic [PHASE_IN_BITS-1:0] phase);
      bit [PHASE_BITS-1:0]  p;
      bit [QUARTER_SHIFT:0] x;
      bit [63:0]            pos;
      bit [63:0]            idx;
      bit [63:0]            frac;
      bit [63:0]            lo;
      bit [63:0]            hi;
      bit [63:0]            slope;
      bit [63:0]            y;
      p = phase[PHASE_BITS-1:0];
      x = {1'b0, p[QUARTER_SHIFT-1:0]};
      if (p[QUARTER_SHIFT]) x = (QUARTER_SHIFT + 1)'(QUARTER - 64'(x));
      pos  = 64'(x) * 64'(SEG2);
      idx  = pos >> QUARTER_SHIFT;
      frac = pos & (QUARTER - 1);
      if (idx >= 64'(SEG2)) begin
         y = 64'(quarter_sine_table[SEG2]);
      end else begin
         lo    = 64'(quarter_sine_table[idx[ADDR_BITS-1:0]]);
         hi    = 64'(quarter_sine_table[ADDR_BITS'(idx + 64'd1)]);
         slope = (hi >= lo) ? (hi - lo) : 64'd0;
         y     = lo + ((slope * frac + (QUARTER >> 1)) >> QUARTER_SHIFT);
      end
      if (p[QUARTER_SHIFT + 1]) y = 64'd0 - y;
      return y[OUT_BITS-1:0];
   endfunction

   // Sends one phase word: an optional idle gap, then start held until accepted.
   task automatic send_phase(input logic [PHASE_IN_BITS-1:0] phase);
      int            gap;
      sine_word_type entry;
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start     <= 1'b1;
      req_phase <= phase;
      do @(posedge clock); while (busy);
      entry.phase = phase;
      entry.sine  = predict_sine(phase);
      pending_sines.push_back(entry);
      words_sent++;
   endtask

   // Compares every result word with the oldest expectation.
   always @(posedge clock) begin
      sine_word_type entry;
      if (!reset && rsp_valid) begin
         if (pending_sines.size() == 0) begin
            $display("%0t: unexpected sine word, expected none, actual %0d",
                     $time, rsp_sine_value);
            mismatches++;
         end else begin
            entry = pending_sines.pop_front();
            words_checked++;
            if (rsp_sine_value !== entry.sine) begin
               $display("%0t: phase %06h sine_value expected %0d, actual %0d",
                        $time, entry.phase, $signed(entry.sine), rsp_sine_value);
               mismatches++;
            end
         end
      end
   end

   // Extremes, quadrant boundaries, and exact sample points.
   task automatic test_directed();
      logic [PHASE_IN_BITS-1:0] phases [$];
      phases = '{24'h000000, 24'h000001, 24'h3FFFFF, 24'h400000, 24'h400001,
                 24'h7FFFFF, 24'h800000, 24'h800001, 24'hBFFFFF, 24'hC00000,
                 24'hC00001, 24'hFFFFFF, 24'h555555, 24'hAAAAAA, 24'h001000,
                 24'h000FFF, 24'h200000, 24'h600000, 24'hA00000, 24'hE00000,
                 24'h3FF000, 24'h7FF000};
      foreach (phases[i]) send_phase(phases[i]);
   endtask

   // Uniform random phases, with stretches of back-to-back words mixed in.
   task automatic test_random_phase(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         send_phase(PHASE_IN_BITS'($urandom()));
      end
      no_gaps = 1'b0;
   endtask

   // Phases on or next to table sample points, in every quadrant.
   task automatic test_sample_points(input int count);
      logic [PHASE_IN_BITS-1:0] phase;
      int                       seg_size;
      seg_size = 1 << (QUARTER_SHIFT - $clog2(SEG2));
      for (int i = 0; i < count; i++) begin
         phase = PHASE_IN_BITS'($urandom_range(0, SEG2) * seg_size);
         phase = phase + PHASE_IN_BITS'($urandom_range(0, 6)) - PHASE_IN_BITS'(3);
         phase[PHASE_BITS-1:QUARTER_SHIFT] = 2'($urandom_range(0, 3));
         send_phase(phase);
      end
   endtask

   // Full-rate stream with no gaps at all.
   task automatic test_back_to_back(input int count);
      no_gaps = 1'b1;
      for (int i = 0; i < count; i++) send_phase(PHASE_IN_BITS'($urandom()));
      no_gaps = 1'b0;
   endtask

   // Hard stop in case the block hangs.
   initial begin
      #2_000_000;
      $display("** quarter_wave_sine_interpolator: FAILED **");
      $finish;
   end

   // Main sequence.
   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_phase     = '0;
      mismatches    = 0;
      words_sent    = 0;
      words_checked = 0;
      no_gaps       = 1'b0;
      build_sine_table();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_phase(500);
      test_sample_points(300);
      test_back_to_back(350);

      @(negedge clock);
      start <= 1'b0;
      while (pending_sines.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d phase words and checked %0d sine words, %0d mismatches.",
               words_sent, words_checked, mismatches);
      $display("Covered quadrant edges, table sample points, random and full-rate phases.");
      if (mismatches == 0) begin
         $display("** quarter_wave_sine_interpolator: PASSED **");
      end else begin
         $display("** quarter_wave_sine_interpolator: FAILED **");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/qwsi_pkg.sv
rtl/qwsi_fold.sv
rtl/qwsi_rom.sv
rtl/qwsi_interp.sv
rtl/quarter_wave_sine_interpolator.sv
sim/tb.sv
